// ===== src/ssfbc_pkg.sv =====
package ssfbc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ADDR_BITS     = 48;

  localparam int SIZE_W       = 32;
  localparam int FIELD_ADDR_W = 48;
  localparam int STATUS_W     = 3;
  localparam int ADDR_STORE_W = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;
  localparam int CNT_W        = $clog2(TABLE_ENTRIES + 1);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_SERVED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STORED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd4;

  typedef struct packed {
    logic [SIZE_W-1:0]       size;
    logic [ADDR_STORE_W-1:0] addr;
  } entry_t;

  // flags handed from a cell to the cell after it
  typedef struct packed {
    logic ge;      // occupied and size >= request
    logic ins_ge;  // free slot, or size >= request
  } cell_link_t;

  typedef struct packed {
    logic insert;
    logic extract;
  } cell_cmd_t;

endpackage

// ===== src/ssfbc_if.sv =====
interface ssfbc_in_if;
  import ssfbc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [SIZE_W-1:0]       req_size;
  logic [FIELD_ADDR_W-1:0] block_addr;

  modport source (output valid, output action, output req_size, output block_addr,
                  input ready);
  modport sink (input valid, input action, input req_size, input block_addr,
                output ready);
endinterface

interface ssfbc_out_if;
  import ssfbc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [FIELD_ADDR_W-1:0] granted_addr;
  logic [SIZE_W-1:0]       granted_size;

  modport source (output valid, output status, output granted_addr, output granted_size,
                  input ready);
  modport sink (input valid, input status, input granted_addr, input granted_size,
                output ready);
endinterface

// ===== src/ssfbc_cell.sv =====
module ssfbc_cell
  import ssfbc_pkg::*;
(
  input  logic              clk,
  input  logic              occupied,
  input  logic [SIZE_W-1:0] req_size,
  input  logic [SIZE_W:0]   req_twice,
  input  entry_t            new_entry,
  input  cell_cmd_t         cmd,
  input  cell_link_t        prev_link,
  output cell_link_t        link,
  input  entry_t            left_entry,
  input  entry_t            right_entry,
  output entry_t            entry,
  output logic              hit,
  output entry_t            hit_entry
);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   first_ge;

  assign entry        = entry_r;
  assign link.ge      = occupied && (entry_r.size >= req_size);
  assign link.ins_ge  = !occupied || (entry_r.size >= req_size);
  assign first_ge     = link.ge && !prev_link.ge;
  assign hit          = first_ge && ({1'b0, entry_r.size} <= req_twice);
  assign hit_entry    = hit ? entry_r : '0;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.insert) begin
      if (prev_link.ins_ge) begin
        entry_nxt = left_entry;
      end else if (link.ins_ge) begin
        entry_nxt = new_entry;
      end
    end else if (cmd.extract && link.ge) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== src/size_sorted_free_block_cache_top.sv =====
// Each request is registered on its input transfer, and its result is registered
// on the output; the next input is taken once the row of cells has done its
// compare-and-shift for this one, which waits while an earlier result is unaccepted.
// Reset (rst_n, synchronous, active low) empties the table and clears
// the pool-used flag; no clearing pass, the block is ready right away.
module size_sorted_free_block_cache_top
  import ssfbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ssfbc_in_if.sink    in_ch,
  ssfbc_out_if.source out_ch
);

  logic                    busy_r, busy_nxt;
  logic                    act_r;
  logic [SIZE_W-1:0]       size_r;
  logic [ADDR_STORE_W-1:0] addr_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    pool_used_r, pool_used_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;
  logic [FIELD_ADDR_W-1:0] gaddr_r, gaddr_nxt;
  logic [SIZE_W-1:0]       gsize_r, gsize_nxt;

  logic                    in_xfer;
  logic                    exec;
  logic [SIZE_W:0]         req_twice;
  entry_t                  new_entry;
  cell_cmd_t               cmd;

  cell_link_t              links [TABLE_ENTRIES+1];
  entry_t                  entries [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hits;
  entry_t                  hit_entries [TABLE_ENTRIES];
  entry_t                  hit_sel;
  logic                    serve;

  assign in_ch.ready         = !busy_r;
  assign in_xfer             = in_ch.valid && !busy_r;
  assign exec                = busy_r && (!out_valid_r || out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.granted_addr = gaddr_r;
  assign out_ch.granted_size = gsize_r;

  assign req_twice      = {size_r, 1'b0};
  assign new_entry.size = size_r;
  assign new_entry.addr = addr_r;
  assign links[0]       = '0;

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      entry_t left_e, right_e;
      if (g == 0) begin : g_first
        assign left_e = entries[0];
      end else begin : g_mid
        assign left_e = entries[g-1];
      end
      if (g == TABLE_ENTRIES - 1) begin : g_last
        assign right_e = entries[g];
      end else begin : g_inner
        assign right_e = entries[g+1];
      end

      ssfbc_cell u_cell (
        .clk        (clk),
        .occupied   (count_r > CNT_W'(g)),
        .req_size   (size_r),
        .req_twice  (req_twice),
        .new_entry  (new_entry),
        .cmd        (cmd),
        .prev_link  (links[g]),
        .link       (links[g+1]),
        .left_entry (left_e),
        .right_entry(right_e),
        .entry      (entries[g]),
        .hit        (hits[g]),
        .hit_entry  (hit_entries[g])
      );
    end
  endgenerate

  always_comb begin
    hit_sel = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_sel = hit_sel | hit_entries[i];
    end
  end

  assign serve = |hits;

  always_comb begin
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    pool_used_nxt = pool_used_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    gaddr_nxt     = gaddr_r;
    gsize_nxt     = gsize_r;
    cmd           = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      busy_nxt = 1'b1;
    end

    if (exec) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      gaddr_nxt     = '0;
      gsize_nxt     = size_r;
      if (act_r == ACT_ALLOC) begin
        if (serve) begin
          status_nxt  = ST_SERVED;
          gaddr_nxt   = FIELD_ADDR_W'(hit_sel.addr);
          gsize_nxt   = hit_sel.size;
          count_nxt   = count_r - CNT_W'(1);
          cmd.extract = 1'b1;
        end else begin
          status_nxt    = ST_MISS;
          pool_used_nxt = 1'b1;
        end
      end else if (!pool_used_r) begin
        status_nxt = ST_IGNORED;
      end else if (count_r >= CNT_W'(TABLE_ENTRIES)) begin
        status_nxt = ST_DROPPED;
      end else begin
        status_nxt = ST_STORED;
        count_nxt  = count_r + CNT_W'(1);
        cmd.insert = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      pool_used_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      pool_used_r <= pool_used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r  <= in_ch.action;
      size_r <= in_ch.req_size;
      addr_r <= in_ch.block_addr[ADDR_STORE_W-1:0];
    end
    status_r <= status_nxt;
    gaddr_r  <= gaddr_nxt;
    gsize_r  <= gsize_nxt;
  end

endmodule

// ===== test/tb_size_sorted_free_block_cache_top.sv =====
`timescale 1ns / 1ps

module tb_size_sorted_free_block_cache_top;
  import ssfbc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic                    action;
    logic [SIZE_W-1:0]       size;
    logic [FIELD_ADDR_W-1:0] addr;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [FIELD_ADDR_W-1:0] addr;
    logic [SIZE_W-1:0]       size;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n;

  ssfbc_in_if  in_ch();
  ssfbc_out_if out_ch();

  size_sorted_free_block_cache_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // free-list shadow
  logic [SIZE_W-1:0]       free_size [TABLE_ENTRIES];
  logic [ADDR_STORE_W-1:0] free_addr [TABLE_ENTRIES];
  int                      free_count   = 0;
  bit                      pool_touched = 1'b0;

  request_t requests_q[$];
  grant_t   grants_due[$];

  bit   in_idle_on  = 1'b1;
  bit   out_idle_on = 1'b1;
  bit   hold_active = 1'b0;
  logic in_taken    = 1'b0;
  int   in_gap      = 0;
  int   out_gap     = 0;
  int   mismatches  = 0;
  int   results_seen = 0;
  int   in_stall_cycles = 0;
  int   quiet_cycles = 0;
  int   status_seen [5] = '{default: 0};
  event hold_go;

  function automatic grant_t serve_request(input logic act, input logic [SIZE_W-1:0] sz,
                                           input logic [FIELD_ADDR_W-1:0] addr);
    grant_t          g;
    logic [SIZE_W:0] twice;
    int              hit;
    int              pos;
    g.status = ST_MISS;
    g.addr   = '0;
    g.size   = sz;
    twice    = {sz, 1'b0};
    if (act == ACT_ALLOC) begin
      hit = -1;
      for (int i = 0; i < free_count; i++) begin
        if ({1'b0, free_size[i]} > twice) break;
        if (free_size[i] >= sz) begin
          hit = i;
          break;
        end
      end
      if (hit < 0) begin
        pool_touched = 1'b1;
      end else begin
        g.status = ST_SERVED;
        g.addr   = FIELD_ADDR_W'(free_addr[hit]);
        g.size   = free_size[hit];
        for (int i = hit; i < free_count - 1; i++) begin
          free_size[i] = free_size[i + 1];
          free_addr[i] = free_addr[i + 1];
        end
        free_count--;
      end
    end else if (!pool_touched) begin
      g.status = ST_IGNORED;
    end else if (free_count >= TABLE_ENTRIES) begin
      g.status = ST_DROPPED;
    end else begin
      pos = free_count;
      for (int i = 0; i < free_count; i++) begin
        if (free_size[i] >= sz) begin
          pos = i;
          break;
        end
      end
      for (int i = free_count; i > pos; i--) begin
        free_size[i] = free_size[i - 1];
        free_addr[i] = free_addr[i - 1];
      end
      free_size[pos] = sz;
      free_addr[pos] = addr[ADDR_STORE_W-1:0];
      free_count++;
      g.status = ST_STORED;
    end
    return g;
  endfunction

  function automatic logic [FIELD_ADDR_W-1:0] rand_addr();
    return FIELD_ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 3);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic request_t mk_req(input logic act, input logic [SIZE_W-1:0] sz,
                                      input logic [FIELD_ADDR_W-1:0] addr);
    request_t r;
    r.action = act;
    r.size   = sz;
    r.addr   = addr;
    return r;
  endfunction

  task automatic add_random(input int n, input int free_pct);
    for (int i = 0; i < n; i++) begin
      requests_q.push_back(mk_req(($urandom_range(0, 99) < free_pct) ? ACT_FREE : ACT_ALLOC,
                                  rand_size(), rand_addr()));
    end
  endtask

  task automatic drain();
    while (requests_q.size() != 0 || in_ch.valid || grants_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic flag_mismatch(input string what, input grant_t want, input grant_t got);
    if (mismatches < REPORT_LIMIT) begin
      $display("ERROR %s at result %0d: expected status %0d addr %h size %h, got status %0d addr %h size %h",
               what, results_seen, want.status, want.addr, want.size,
               got.status, got.addr, got.size);
    end
    mismatches++;
  endtask

  // request driver
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // hold until transfer
    end else if (in_gap > 0) begin
      in_gap--;
      in_ch.valid <= 1'b0;
    end else if (requests_q.size() != 0 && in_idle_on && $urandom_range(0, 11) == 0) begin
      in_gap = $urandom_range(0, 18);
      in_ch.valid <= 1'b0;
    end else if (requests_q.size() != 0) begin
      nxt = requests_q.pop_front();
      in_ch.valid      <= 1'b1;
      in_ch.action     <= nxt.action;
      in_ch.req_size   <= nxt.size;
      in_ch.block_addr <= nxt.addr;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // result-side ready
  always @(negedge clk) begin : drive_ready
    if (!rst_n || hold_active) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (out_idle_on && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 18);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always begin : long_hold
    @(hold_go);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin : watch_ports
    grant_t got;
    grant_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      grants_due.push_back(serve_request(in_ch.action, in_ch.req_size, in_ch.block_addr));
    end
    if (rst_n && in_ch.valid && !in_ch.ready) in_stall_cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status = out_ch.status;
      got.addr   = out_ch.granted_addr;
      got.size   = out_ch.granted_size;
      if (got.status <= ST_DROPPED) status_seen[got.status]++;
      if (grants_due.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = grants_due.pop_front();
        if (got.status !== want.status || got.addr !== want.addr || got.size !== want.size) begin
          flag_mismatch("mismatch", want, got);
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, grants_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_ALLOC;
    in_ch.req_size   = '0;
    in_ch.block_addr = '0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // free before the pool was ever used, then first miss with a zero request
    requests_q.push_back(mk_req(ACT_FREE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    requests_q.push_back(mk_req(ACT_ALLOC, 32'd0, rand_addr()));
    requests_q.push_back(mk_req(ACT_FREE, 32'd0, 48'd0));
    requests_q.push_back(mk_req(ACT_FREE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    // equal sizes: the later block goes first
    requests_q.push_back(mk_req(ACT_FREE, 32'd100, 48'h0000_0000_A000));
    requests_q.push_back(mk_req(ACT_FREE, 32'd100, 48'h0000_0000_B000));
    requests_q.push_back(mk_req(ACT_FREE, 32'd300, 48'h5555_5555_5555));
    for (int i = 0; i < 11; i++) begin
      requests_q.push_back(mk_req(ACT_FREE, 32'd1000 + i, rand_addr()));
    end
    // table full
    requests_q.push_back(mk_req(ACT_FREE, 32'd7, 48'hAAAA_AAAA_AAAA));
    requests_q.push_back(mk_req(ACT_ALLOC, 32'd0, rand_addr()));
    // twice the request past 32 bits
    requests_q.push_back(mk_req(ACT_ALLOC, 32'h8000_0000, rand_addr()));
    requests_q.push_back(mk_req(ACT_ALLOC, 32'd100, rand_addr()));
    requests_q.push_back(mk_req(ACT_ALLOC, 32'd100, rand_addr()));
    // smallest fit too large
    requests_q.push_back(mk_req(ACT_ALLOC, 32'd100, rand_addr()));
    requests_q.push_back(mk_req(ACT_ALLOC, 32'd150, rand_addr()));
    drain();

    add_random(350, 50);
    drain();

    // output held off while input keeps coming
    in_idle_on = 1'b0;
    -> hold_go;
    add_random(60, 70);
    drain();
    in_idle_on = 1'b1;

    add_random(350, 65);
    drain();

    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    add_random(250, 45);
    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests: %0d served, %0d misses, %0d stored, %0d ignored, %0d dropped",
             results_seen, status_seen[ST_SERVED], status_seen[ST_MISS],
             status_seen[ST_STORED], status_seen[ST_IGNORED], status_seen[ST_DROPPED]);
    $display("Input back-pressured for %0d cycles; %0d mismatching results",
             in_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
